@@ rtl/tfn_pkg.sv @@
// Package for the triangle face normal block.
// Widths, the side-band struct and helper functions; no dependencies.
package tfn_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int IDX_W            = 16;

  // Datapath widths
  localparam int EDGE_W   = COORD_WIDTH + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int MAG_W    = CROSS_W;
  localparam int SH_W     = $clog2(MAG_W + 1);
  localparam int TARGET_BITS = 31;
  localparam int SQ_W     = 2 * TARGET_BITS + 2;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int NORM_W   = NORMAL_FRAC_BITS + 2;
  localparam int Q_W      = NORMAL_FRAC_BITS + 2;
  localparam int NUM_W    = TARGET_BITS + NORMAL_FRAC_BITS + 1;
  localparam int DIV_W    = ROOT_W + Q_W;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    logic [2:0][IDX_W-1:0] idx;
    logic [2:0]            neg;
    logic                  zero;
  } meta_t;

  // Side band through the square root unit
  typedef struct packed {
    meta_t                       meta;
    logic [2:0][TARGET_BITS-1:0] s;
  } side_t;

  // Number of significant bits of a magnitude
  function automatic logic [SH_W-1:0] bit_len(input logic [MAG_W-1:0] v);
    logic [SH_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) n = SH_W'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ rtl/tfn_in_if.sv @@
// Input channel: one triangle word per handshake.
// Depends on tfn_pkg.
interface tfn_in_if import tfn_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p0_x, p0_y, p0_z;
  logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
  logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z;
  logic [IDX_W-1:0]              index0, index1, index2;

  modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, index0, index1, index2, input ready);
  modport sink   (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                  p2_x, p2_y, p2_z, index0, index1, index2, output ready);
endinterface

@@ rtl/tfn_out_if.sv @@
// Output channel: one normal word per handshake.
// Depends on tfn_pkg.
interface tfn_out_if import tfn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic [IDX_W-1:0]         out_index0, out_index1, out_index2;
  logic                     degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, out_index0,
                  out_index1, out_index2, degenerate, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, out_index0,
                  out_index1, out_index2, degenerate, output ready);
endinterface

@@ rtl/triangle_face_normal.sv @@
// Top level of the triangle face normal block.
// Depends on tfn_pkg, tfn_in_if, tfn_out_if and tfn_sqrt.
//
// Usage:
//   tri_i carries one triangle per word: three Q8.16 vertices and three
//   vertex indices. nrm_o returns one word per triangle: the unit normal in
//   Q1.14 (rounded to nearest), the indices unchanged and a degenerate flag
//   that is set, with a zero normal, when the cross product is zero.
//   Both channels use valid/ready; a word moves when both are high.
// Throughput: one triangle per clock cycle while nrm_o does not stall.
// Pipeline: 8 stages of edges, cross product, normalize and squares, 32
//   square root stages (one root bit each), 17 divider stages (one quotient
//   bit each, plus setup) and the output register.
// Reset: all valid bits clear; no result is presented after reset.
// Stall: the whole pipeline holds while a result waits on nrm_o; tri_i.ready
//   follows that, so nothing is lost or repeated.
module triangle_face_normal import tfn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfn_in_if.sink    tri_i,
  tfn_out_if.source nrm_o
);

  logic en;
  logic out_v_q;

  assign en          = !out_v_q || nrm_o.ready;
  assign tri_i.ready = en;

  // Stage 1: edges
  logic                     v1_q;
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e2_q [3];
  meta_t                    m1_q;

  // Stage 2: products
  logic                     v2_q;
  logic signed [PROD_W-1:0] pr_q [6];
  meta_t                    m2_q;

  // Stage 3: cross product
  logic                      v3_q;
  logic signed [CROSS_W-1:0] cr_q [3];
  meta_t                     m3_q;

  // Stage 4: magnitudes
  logic             v4_q;
  logic [MAG_W-1:0] mg4_q [3];
  meta_t            m4_q;

  // Stage 5: shift amount
  logic             v5_q;
  logic [MAG_W-1:0] mg5_q [3];
  logic [SH_W-1:0]  sh_q;
  logic             rgt_q;
  meta_t            m5_q;

  // Stage 6: normalized magnitudes
  logic                   v6_q;
  logic [TARGET_BITS-1:0] s6_q [3];
  meta_t                  m6_q;

  // Stage 7: squares
  logic                     v7_q;
  logic [2*TARGET_BITS-1:0] sq_q [3];
  logic [TARGET_BITS-1:0]   s7_q [3];
  meta_t                    m7_q;

  // Stage 8: sum of squares
  logic            v8_q;
  logic [SQ_W-1:0] sum_q;
  side_t           sd8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v1_q <= tri_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  // Front datapath: edges through sum of squares
  logic [SH_W-1:0] maxlen;
  assign maxlen = bit_len(mg4_q[0] | mg4_q[1] | mg4_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q[0] <= EDGE_W'(tri_i.p1_x) - EDGE_W'(tri_i.p0_x);
      e1_q[1] <= EDGE_W'(tri_i.p1_y) - EDGE_W'(tri_i.p0_y);
      e1_q[2] <= EDGE_W'(tri_i.p1_z) - EDGE_W'(tri_i.p0_z);
      e2_q[0] <= EDGE_W'(tri_i.p2_x) - EDGE_W'(tri_i.p0_x);
      e2_q[1] <= EDGE_W'(tri_i.p2_y) - EDGE_W'(tri_i.p0_y);
      e2_q[2] <= EDGE_W'(tri_i.p2_z) - EDGE_W'(tri_i.p0_z);
      m1_q.idx  <= {tri_i.index2, tri_i.index1, tri_i.index0};
      m1_q.neg  <= '0;
      m1_q.zero <= 1'b0;

      pr_q[0] <= PROD_W'(e1_q[1]) * PROD_W'(e2_q[2]);
      pr_q[1] <= PROD_W'(e1_q[2]) * PROD_W'(e2_q[1]);
      pr_q[2] <= PROD_W'(e1_q[2]) * PROD_W'(e2_q[0]);
      pr_q[3] <= PROD_W'(e1_q[0]) * PROD_W'(e2_q[2]);
      pr_q[4] <= PROD_W'(e1_q[0]) * PROD_W'(e2_q[1]);
      pr_q[5] <= PROD_W'(e1_q[1]) * PROD_W'(e2_q[0]);
      m2_q    <= m1_q;

      for (int i = 0; i < 3; i++) begin
        cr_q[i] <= CROSS_W'(pr_q[2*i]) - CROSS_W'(pr_q[2*i+1]);
      end
      m3_q <= m2_q;

      for (int i = 0; i < 3; i++) begin
        mg4_q[i] <= cr_q[i][CROSS_W-1] ? MAG_W'(-cr_q[i]) : MAG_W'(cr_q[i]);
      end
      m4_q.idx <= m3_q.idx;
      m4_q.neg <= {cr_q[2][CROSS_W-1], cr_q[1][CROSS_W-1], cr_q[0][CROSS_W-1]};
      m4_q.zero <= 1'b0;

      mg5_q <= mg4_q;
      if (maxlen > SH_W'(TARGET_BITS)) begin
        rgt_q <= 1'b1;
        sh_q  <= maxlen - SH_W'(TARGET_BITS);
      end else begin
        rgt_q <= 1'b0;
        sh_q  <= SH_W'(TARGET_BITS) - maxlen;
      end
      m5_q.idx  <= m4_q.idx;
      m5_q.neg  <= m4_q.neg;
      m5_q.zero <= (maxlen == '0);

      for (int i = 0; i < 3; i++) begin
        s6_q[i] <= rgt_q ? TARGET_BITS'(mg5_q[i] >> sh_q)
                         : TARGET_BITS'(mg5_q[i] << sh_q);
      end
      m6_q <= m5_q;

      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (2*TARGET_BITS)'(s6_q[i]) * (2*TARGET_BITS)'(s6_q[i]);
      end
      s7_q <= s6_q;
      m7_q <= m6_q;

      sum_q <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
      sd8_q.meta <= m7_q;
      sd8_q.s    <= {s7_q[2], s7_q[1], s7_q[0]};
    end
  end

  // Square root of the sum of squares
  logic              sr_v;
  logic [ROOT_W-1:0] sr_root;
  side_t             sr_side;

  tfn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .x_i     (sum_q),
    .side_i  (sd8_q),
    .valid_o (sr_v),
    .root_o  (sr_root),
    .side_o  (sr_side)
  );

  // Divider: entry 0 is the setup register, one quotient bit per stage
  logic [Q_W:0]       dv_q;
  logic [DIV_W-1:0]   rem_q [Q_W+1][3];
  logic [Q_W-1:0]     quo_q [Q_W+1][3];
  logic [ROOT_W-1:0]  len_q [Q_W+1];
  meta_t              dm_q  [Q_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= sr_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= (DIV_W'(sr_side.s[i]) << NORMAL_FRAC_BITS)
                       + DIV_W'(sr_root >> 1);
        quo_q[0][i] <= '0;
      end
      len_q[0] <= sr_root;
      dm_q[0]  <= sr_side.meta;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int Sh = Q_W - 1 - k;
    logic [DIV_W-1:0] dvs;
    assign dvs = DIV_W'(len_q[k]) << Sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[k][i] >= dvs) begin
            rem_q[k+1][i] <= rem_q[k][i] - dvs;
            quo_q[k+1][i] <= quo_q[k][i] | (Q_W'(1) << Sh);
          end else begin
            rem_q[k+1][i] <= rem_q[k][i];
            quo_q[k+1][i] <= quo_q[k][i];
          end
        end
        len_q[k+1] <= len_q[k];
        dm_q[k+1]  <= dm_q[k];
      end
    end
  end

  // Output register: clamp, sign, degenerate override
  localparam logic [Q_W-1:0] One = Q_W'(1) << NORMAL_FRAC_BITS;
  logic [NORM_W-1:0] nrm_d [3];
  logic [NORM_W-1:0] nrm_q [3];
  meta_t             om_q;

  always_comb begin
    logic [Q_W-1:0] qc;
    for (int i = 0; i < 3; i++) begin
      qc = (quo_q[Q_W][i] > One) ? One : quo_q[Q_W][i];
      if (dm_q[Q_W].zero) begin
        nrm_d[i] = '0;
      end else if (dm_q[Q_W].neg[i]) begin
        nrm_d[i] = NORM_W'(-qc);
      end else begin
        nrm_d[i] = NORM_W'(qc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_q <= nrm_d;
      om_q  <= dm_q[Q_W];
    end
  end

  assign nrm_o.valid      = out_v_q;
  assign nrm_o.normal_x   = nrm_q[0];
  assign nrm_o.normal_y   = nrm_q[1];
  assign nrm_o.normal_z   = nrm_q[2];
  assign nrm_o.out_index0 = om_q.idx[0];
  assign nrm_o.out_index1 = om_q.idx[1];
  assign nrm_o.out_index2 = om_q.idx[2];
  assign nrm_o.degenerate = om_q.zero;

endmodule

@@ rtl/tfn_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with side band.
// Depends on tfn_pkg.
module tfn_sqrt import tfn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   x_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic [ROOT_W:1]   v_q;
  logic [SQ_W-1:0]   x_q [1:ROOT_W];
  logic [SQ_W-1:0]   r_q [1:ROOT_W];
  side_t             sd_q [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic            v_in;
    logic [SQ_W-1:0] x_in, r_in;
    side_t           sd_in;
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] x_d, r_d;

    // Stage inputs: ports for the first stage, previous registers after that
    if (k == 0) begin : g_head
      assign v_in  = valid_i;
      assign x_in  = x_i;
      assign r_in  = '0;
      assign sd_in = side_i;
    end else begin : g_tail
      assign v_in  = v_q[k];
      assign x_in  = x_q[k];
      assign r_in  = r_q[k];
      assign sd_in = sd_q[k];
    end

    // Restoring step: try subtracting r + bit
    always_comb begin
      trial = r_in + Bit;
      if (x_in >= trial) begin
        x_d = x_in - trial;
        r_d = (r_in >> 1) + Bit;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1]  <= x_d;
        r_q[k+1]  <= r_d;
        sd_q[k+1] <= sd_in;
      end
    end
  end

  assign valid_o = v_q[ROOT_W];
  assign root_o  = r_q[ROOT_W][ROOT_W-1:0];
  assign side_o  = sd_q[ROOT_W];

endmodule

@@ rtl/tfn_checker.sv @@
// Port-level checks for triangle_face_normal, attached by bind.
// Depends on tfn_pkg.
module tfn_checker import tfn_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic signed [NORM_W-1:0] nx_i,
  input logic signed [NORM_W-1:0] ny_i,
  input logic signed [NORM_W-1:0] nz_i,
  input logic                     degen_i
);

  localparam logic signed [NORM_W-1:0] Pos = NORM_W'(1) << NORMAL_FRAC_BITS;
  localparam logic signed [NORM_W-1:0] Neg = -Pos;

  // A waiting result stays up
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Input side only stalls while a result is held
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not track output stall");

  // Degenerate triangles give a zero normal
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degen_i |-> nx_i == '0 && ny_i == '0 && nz_i == '0)
    else $error("degenerate result with nonzero normal");

  // Components stay within unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> nx_i <= Pos && nx_i >= Neg && ny_i <= Pos && ny_i >= Neg
                    && nz_i <= Pos && nz_i >= Neg)
    else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (tri_i.ready),
  .out_valid_i (nrm_o.valid),
  .out_ready_i (nrm_o.ready),
  .nx_i        (nrm_o.normal_x),
  .ny_i        (nrm_o.normal_y),
  .nz_i        (nrm_o.normal_z),
  .degen_i     (nrm_o.degenerate)
);

@@ tb/sv/triangle_face_normal_test.sv @@
// Self-checking bench for triangle_face_normal: directed triangles, then random ones.
// Results are checked field by field against a built-in face normal predictor.
// Depends on tfn_pkg, tfn_in_if, tfn_out_if and the block itself.
module triangle_face_normal_test;
  import tfn_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RANDOM_TRIS = 1330;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_ONE = COORD_WIDTH'(65536);
  localparam logic signed [NORM_W-1:0] N_ONE = NORM_W'(1 << NORMAL_FRAC_BITS);

  typedef struct {
    logic signed [COORD_WIDTH-1:0] pos [9];
    logic [IDX_W-1:0]              idx [3];
  } tri_t;

  typedef struct {
    logic signed [NORM_W-1:0] n [3];
    logic [IDX_W-1:0]         idx [3];
    logic                     degen;
  } normal_t;

  typedef struct {
    tri_t    t;
    bit      known;
    normal_t n;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tfn_in_if  tri_if ();
  tfn_out_if nrm_if ();

  triangle_face_normal uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tri_i  (tri_if),
    .nrm_o  (nrm_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  normal_t pending_normals [$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      idle_on = 1'b1;

  // Floor of the square root of a 64-bit value
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit face normal of one triangle
  function automatic normal_t face_normal(input tri_t t);
    longint      e1 [3];
    longint      e2 [3];
    longint      c [3];
    logic [63:0] mag [3];
    logic [63:0] s [3];
    logic [63:0] len;
    logic [63:0] q;
    int          maxlen;
    int          bl;
    normal_t     r;
    maxlen = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t.pos[3+i]) - longint'(t.pos[i]);
      e2[i] = longint'(t.pos[6+i]) - longint'(t.pos[i]);
      r.idx[i] = t.idx[i];
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
      bl = 0;
      for (int k = 0; k < 64; k++) if (mag[i][k]) bl = k + 1;
      if (bl > maxlen) maxlen = bl;
    end
    if (maxlen == 0) begin
      for (int i = 0; i < 3; i++) r.n[i] = '0;
      r.degen = 1'b1;
      return r;
    end
    // Common shift so the largest magnitude has exactly 31 bits
    for (int i = 0; i < 3; i++)
      s[i] = (maxlen > TARGET_BITS) ? mag[i] >> (maxlen - TARGET_BITS)
                                    : mag[i] << (TARGET_BITS - maxlen);
    len = int_sqrt(s[0] * s[0] + s[1] * s[1] + s[2] * s[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((s[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
      if (q > (64'd1 << NORMAL_FRAC_BITS)) q = 64'd1 << NORMAL_FRAC_BITS;
      r.n[i] = (c[i] < 0) ? NORM_W'(-q) : NORM_W'(q);
    end
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic tri_t make_tri(
    input logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
    input logic [IDX_W-1:0] i0, i1, i2);
    tri_t t;
    t.pos = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    t.idx = '{i0, i1, i2};
    return t;
  endfunction

  function automatic normal_t make_normal(
    input logic signed [NORM_W-1:0] nx, ny, nz, input tri_t t, input logic dg);
    normal_t r;
    r.n = '{nx, ny, nz};
    r.idx = t.idx;
    r.degen = dg;
    return r;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    return COORD_WIDTH'($urandom);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Random triangle of one of several shapes
  function automatic tri_t rand_tri();
    tri_t t;
    int   kind;
    int   k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) t.idx[i] = IDX_W'($urandom);
    for (int i = 0; i < 9; i++) t.pos[i] = rand_coord();
    case (kind)
      4, 5, 6: begin
        // small triangle near a random point
        for (int i = 0; i < 3; i++) begin
          t.pos[i] = COORD_WIDTH'($urandom_range(0, 8388606) - 4194303);
          t.pos[3+i] = t.pos[i] + COORD_WIDTH'($urandom_range(0, 2046) - 1023);
          t.pos[6+i] = t.pos[i] + COORD_WIDTH'($urandom_range(0, 2046) - 1023);
        end
      end
      7: begin
        // collinear: p2 on the line through p0 and p1
        k = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
          t.pos[i] = COORD_WIDTH'($urandom_range(0, 2097150) - 1048575);
          t.pos[3+i] = t.pos[i] + COORD_WIDTH'($urandom_range(0, 131070) - 65535);
          t.pos[6+i] = t.pos[i] + COORD_WIDTH'(k) * (t.pos[3+i] - t.pos[i]);
        end
      end
      8: begin
        // two or three coincident points
        for (int i = 0; i < 3; i++) t.pos[3+i] = t.pos[i];
        if ($urandom_range(0, 1)) for (int i = 0; i < 3; i++) t.pos[6+i] = t.pos[i];
      end
      9: begin
        for (int i = 0; i < 9; i++) t.pos[i] = edge_coord();
      end
      default: ;
    endcase
    return t;
  endfunction

  // Drive one triangle and wait for it to be taken
  task automatic send_tri(input tri_t t, input bit has_known, input normal_t known);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      tri_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tri_if.valid  <= 1'b1;
    tri_if.p0_x   <= t.pos[0];
    tri_if.p0_y   <= t.pos[1];
    tri_if.p0_z   <= t.pos[2];
    tri_if.p1_x   <= t.pos[3];
    tri_if.p1_y   <= t.pos[4];
    tri_if.p1_z   <= t.pos[5];
    tri_if.p2_x   <= t.pos[6];
    tri_if.p2_y   <= t.pos[7];
    tri_if.p2_z   <= t.pos[8];
    tri_if.index0 <= t.idx[0];
    tri_if.index1 <= t.idx[1];
    tri_if.index2 <= t.idx[2];
    @(posedge clk_i);
    while (!tri_if.ready) @(posedge clk_i);
    pending_normals.insert(pending_normals.size(), has_known ? known : face_normal(t));
  endtask

  task automatic report_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  // Result side: random stalls, compare each accepted word
  initial begin
    int      stall;
    normal_t e;
    nrm_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        nrm_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      nrm_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!nrm_if.valid) @(posedge clk_i);
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: normal word with none expected");
      end else begin
        e = pending_normals.pop_front();
        report_field("normal_x", e.n[0], nrm_if.normal_x);
        report_field("normal_y", e.n[1], nrm_if.normal_y);
        report_field("normal_z", e.n[2], nrm_if.normal_z);
        report_field("out_index0", e.idx[0], nrm_if.out_index0);
        report_field("out_index1", e.idx[1], nrm_if.out_index1);
        report_field("out_index2", e.idx[2], nrm_if.out_index2);
        report_field("degenerate", e.degen, nrm_if.degenerate);
      end
    end
  end

  // Watchdog: cycles without any word moving
  always @(posedge clk_i) begin
    if ((tri_if.valid && tri_if.ready) || (nrm_if.valid && nrm_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("triangle_face_normal_test failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    row_t    rows [$];
    row_t    r;
    tri_t    t;
    normal_t none;
    tri_if.valid = 1'b0;
    tri_if.p0_x = '0; tri_if.p0_y = '0; tri_if.p0_z = '0;
    tri_if.p1_x = '0; tri_if.p1_y = '0; tri_if.p1_z = '0;
    tri_if.p2_x = '0; tri_if.p2_y = '0; tri_if.p2_z = '0;
    tri_if.index0 = '0; tri_if.index1 = '0; tri_if.index2 = '0;
    none = make_normal('0, '0, '0, make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);

    // Directed rows: typed results where obvious, otherwise predicted
    t = make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(0, 0, 0, t, 1'b1)});
    t = make_tri(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                 16'hFFFF, 16'hFFFF, 16'hFFFF);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(0, 0, 0, t, 1'b1)});
    t = make_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                 16'h1234, 16'h8000, 16'h0001);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(0, 0, 0, t, 1'b1)});
    t = make_tri(0, 0, 0, C_ONE, 0, 0, 0, C_ONE, 0, 16'd1, 16'd2, 16'd3);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(0, 0, N_ONE, t, 1'b0)});
    t = make_tri(0, 0, 0, 0, C_ONE, 0, C_ONE, 0, 0, 16'd4, 16'd5, 16'd6);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(0, 0, -N_ONE, t, 1'b0)});
    t = make_tri(0, 0, 0, C_ONE, 0, 0, 0, 0, C_ONE, 16'hFFFF, 16'h0000, 16'hAAAA);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(0, -N_ONE, 0, t, 1'b0)});
    t = make_tri(0, 0, 0, 0, C_ONE, 0, 0, 0, C_ONE, 16'h5555, 16'hFFFF, 16'h0000);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(N_ONE, 0, 0, t, 1'b0)});
    // single LSB triangle, smallest nonzero cross product
    t = make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 16'd7, 16'd8, 16'd9);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(0, 0, N_ONE, t, 1'b0)});
    // largest edges, opposite corners
    rows.insert(rows.size(),
                row_t'{make_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                                16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, none});
    rows.insert(rows.size(),
                row_t'{make_tri(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX,
                                16'h0, 16'hFFFF, 16'h0), 1'b0, none});
    rows.insert(rows.size(),
                row_t'{make_tri(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN,
                                16'h8001, 16'h7FFE, 16'h0F0F), 1'b0, none});
    // oblique and diagonal cases
    rows.insert(rows.size(),
                row_t'{make_tri(0, 0, 0, C_ONE, C_ONE, 0, 0, C_ONE, C_ONE,
                                16'd10, 16'd11, 16'd12), 1'b0, none});
    rows.insert(rows.size(),
                row_t'{make_tri(-1, -1, -1, 0, 0, 1, 1, 0, 0, 16'd13, 16'd14, 16'd15),
                       1'b0, none});
    rows.insert(rows.size(),
                row_t'{make_tri(C_MAX, 0, 0, 0, C_MAX, 0, 0, 0, C_MAX,
                                16'd16, 16'd17, 16'd18), 1'b0, none});
    // collinear, not coincident
    t = make_tri(0, 0, 0, C_ONE, C_ONE, C_ONE, 2 * C_ONE, 2 * C_ONE, 2 * C_ONE,
                 16'd19, 16'd20, 16'd21);
    rows.insert(rows.size(), row_t'{t, 1'b1, make_normal(0, 0, 0, t, 1'b1)});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      r = rows[i];
      send_tri(r.t, r.known, r.n);
    end

    // Hold the input until everything in flight has come out
    tri_if.valid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);

    for (int i = 0; i < RANDOM_TRIS; i++) begin
      if (i % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == RANDOM_TRIS / 2) begin
        tri_if.valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk_i);
      end
      send_tri(rand_tri(), 1'b0, none);
    end
    tri_if.valid <= 1'b0;

    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("triangle_face_normal_test passed");
    end else begin
      $display("triangle_face_normal_test failed");
    end
    $finish;
  end

endmodule
